/* rtl/swfn_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package swfn_pkg;

    // Default window depth and sample width
    localparam int WINDOW_MAX_DEF  = 1024;
    localparam int SAMPLE_BITS_DEF = 32;

    // Fixed field widths
    localparam int POS_W = 16;
    localparam int CFG_W = 11;

    // Command from the control logic to one cell of the chain
    typedef struct packed {
        logic shift;   // take the right neighbor's entry
        logic load;    // take the new entry
    } cell_cmd_t;

endpackage

`default_nettype wire

/* rtl/swfn_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface swfn_in_if #(
    parameter int SAMPLE_BITS = 32
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last_in_sequence;

    modport source (output valid, output sample, output last_in_sequence, input ready);
    modport sink   (input valid, input sample, input last_in_sequence, output ready);
endinterface

`default_nettype wire

/* rtl/swfn_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface swfn_out_if #(
    parameter int SAMPLE_BITS = 32
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] first_negative;
    logic                          has_negative;
    logic                          end_of_sequence;

    modport source (output valid, output first_negative, output has_negative,
                    output end_of_sequence, input ready);
    modport sink   (input valid, input first_negative, input has_negative,
                    input end_of_sequence, output ready);
endinterface

`default_nettype wire

/* rtl/swfn_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module swfn_cell
    import swfn_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  wire logic                   clk,
    input  wire cell_cmd_t              cmd,
    input  wire logic [POS_W-1:0]       right_pos,
    input  wire logic [SAMPLE_BITS-1:0] right_val,
    input  wire logic [POS_W-1:0]       new_pos,
    input  wire logic [SAMPLE_BITS-1:0] new_val,
    output logic      [POS_W-1:0]       pos,
    output logic      [SAMPLE_BITS-1:0] val
);

    logic [POS_W-1:0]       pos_reg;
    logic [POS_W-1:0]       pos_next;
    logic [SAMPLE_BITS-1:0] val_reg;
    logic [SAMPLE_BITS-1:0] val_next;

    // Load the new entry, advance from the right neighbor, or hold
    always_comb
    begin
        pos_next = pos_reg;
        val_next = val_reg;
        if (cmd.load)
        begin
            pos_next = new_pos;
            val_next = new_val;
        end
        else if (cmd.shift)
        begin
            pos_next = right_pos;
            val_next = right_val;
        end
    end

    // Hold the entry; payload needs no reset
    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        val_reg <= val_next;
    end

    assign pos = pos_reg;
    assign val = val_reg;

endmodule

`default_nettype wire

/* rtl/sliding_window_first_negative_core.sv */
// First negative sample in a sliding window of K samples.
// Channels: samples (sink) carries one signed sample and a last_in_sequence
// mark per request; results (source) carries first_negative, has_negative and
// end_of_sequence. cfg_wr_en / cfg_wr_data write the window size K (0 reads
// as 1, values above WINDOW_MAX read as WINDOW_MAX); write it only while idle.
// Negative samples sit in a chain of WINDOW_MAX cells with the oldest in cell
// zero; the chain advances one cell when the front entry leaves the window and
// the new negative sample drops into the first free cell in the same cycle.
// Throughput: one request per cycle while results is not stalled. Each result
// is registered: it appears on results in the cycle after its sample is
// accepted, set by the single stage of front-entry age compare and chain
// update feeding the output register. The first K-1 samples of a sequence
// give no result; after a request marked last_in_sequence the window state
// clears. When results is stalled the output register holds its request and
// samples.ready drops until the result is taken; a sample arriving in the
// same cycle the result is taken is accepted.
// Reset (rst_n low, asynchronous) empties the window, sets K to 1 and drops
// results.valid; there is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module sliding_window_first_negative_core
    import swfn_pkg::*;
#(
    parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    swfn_in_if.sink               samples,
    swfn_out_if.source            results,
    input  wire logic             cfg_wr_en,
    input  wire logic [CFG_W-1:0] cfg_wr_data
);

    localparam int CNT_W = $clog2(WINDOW_MAX + 1);

    // Control state
    logic [CFG_W-1:0] window_size_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic             filled_reg;
    logic             filled_next;
    logic             out_valid_reg;

    // Output payload
    logic signed [SAMPLE_BITS-1:0] first_neg_reg;
    logic signed [SAMPLE_BITS-1:0] first_neg_next;
    logic                          has_neg_reg;
    logic                          has_neg_next;
    logic                          eos_reg;

    // Chain taps
    logic [POS_W-1:0]       cell_pos [WINDOW_MAX];
    logic [SAMPLE_BITS-1:0] cell_val [WINDOW_MAX];
    cell_cmd_t              cell_cmd [WINDOW_MAX];

    logic             accept;
    logic             neg;
    logic [CFG_W-1:0] k_eff;
    logic [POS_W-1:0] age;
    logic             pop;
    logic             push;
    logic [CNT_W-1:0] count_pop;
    logic             produce;

    assign samples.ready = !out_valid_reg || results.ready;
    assign accept        = samples.valid && samples.ready;
    assign neg           = samples.sample[SAMPLE_BITS-1];

    // Clamp the window size into range
    always_comb
    begin
        if (window_size_reg == '0)
            k_eff = CFG_W'(1);
        else if (32'(window_size_reg) > WINDOW_MAX)
            k_eff = CFG_W'(WINDOW_MAX);
        else
            k_eff = window_size_reg;
    end

    // Drop the front entry once it has aged out, append a negative sample
    always_comb
    begin
        age       = pos_reg - cell_pos[0];
        pop       = (count_reg != '0) && (age >= POS_W'(k_eff));
        count_pop = count_reg - CNT_W'(pop);
        push      = neg && (32'(count_pop) < WINDOW_MAX);
        count_next = count_pop + CNT_W'(push);
        filled_next = filled_reg ||
                      ((({1'b0, pos_reg}) + (POS_W+1)'(1)) >= (POS_W+1)'(k_eff));
        produce   = filled_next;
        pos_next  = pos_reg + POS_W'(1);
    end

    // Select the window's earliest negative sample after the update
    always_comb
    begin
        if (count_next == '0)
        begin
            first_neg_next = '0;
            has_neg_next   = 1'b0;
        end
        else if (count_pop == '0)
        begin
            first_neg_next = samples.sample;
            has_neg_next   = 1'b1;
        end
        else if (pop)
        begin
            first_neg_next = cell_val[1];
            has_neg_next   = 1'b1;
        end
        else
        begin
            first_neg_next = cell_val[0];
            has_neg_next   = 1'b1;
        end
    end

    // Build the chain of cells
    for (genvar i = 0; i < WINDOW_MAX; i++)
    begin : g_cell
        always_comb
        begin
            cell_cmd[i].shift = accept && pop;
            cell_cmd[i].load  = accept && push && (count_pop == CNT_W'(i));
        end

        if (i == WINDOW_MAX - 1)
        begin : g_end
            swfn_cell #(
                .SAMPLE_BITS (SAMPLE_BITS)
            ) u_cell (
                .clk       (clk),
                .cmd       (cell_cmd[i]),
                .right_pos (cell_pos[i]),
                .right_val (cell_val[i]),
                .new_pos   (pos_reg),
                .new_val   (samples.sample),
                .pos       (cell_pos[i]),
                .val       (cell_val[i])
            );
        end
        else
        begin : g_mid
            swfn_cell #(
                .SAMPLE_BITS (SAMPLE_BITS)
            ) u_cell (
                .clk       (clk),
                .cmd       (cell_cmd[i]),
                .right_pos (cell_pos[i+1]),
                .right_val (cell_val[i+1]),
                .new_pos   (pos_reg),
                .new_val   (samples.sample),
                .pos       (cell_pos[i]),
                .val       (cell_val[i])
            );
        end
    end

    // Hold the window size
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            window_size_reg <= CFG_W'(1);
        else if (cfg_wr_en)
            window_size_reg <= cfg_wr_data;
    end

    // Advance the window state on each request; clear after the last one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            pos_reg    <= '0;
            filled_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (samples.last_in_sequence)
            begin
                count_reg  <= '0;
                pos_reg    <= '0;
                filled_reg <= 1'b0;
            end
            else
            begin
                count_reg  <= count_next;
                pos_reg    <= pos_next;
                filled_reg <= filled_next;
            end
        end
    end

    // Hold the result until the receiver takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= produce;
        else if (results.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept && produce)
        begin
            first_neg_reg <= first_neg_next;
            has_neg_reg   <= has_neg_next;
            eos_reg       <= samples.last_in_sequence;
        end
    end

    assign results.valid           = out_valid_reg;
    assign results.first_negative  = first_neg_reg;
    assign results.has_negative    = has_neg_reg;
    assign results.end_of_sequence = eos_reg;

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= WINDOW_MAX)
        else $error("negative count exceeds chain depth");

    a_no_neg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !has_neg_reg) |-> (first_neg_reg == '0))
        else $error("empty window must report zero");

    a_neg_sign: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && has_neg_reg) |-> first_neg_reg[SAMPLE_BITS-1])
        else $error("reported value is not negative");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && samples.last_in_sequence) |=>
            (count_reg == '0 && pos_reg == '0 && !filled_reg))
        else $error("window state not cleared after last sample");

    a_eos_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && produce) |=> out_valid_reg)
        else $error("result lost after accepted request");

endmodule

`default_nettype wire
